>>> sv/iamh_pkg.sv
// Shared types and constants of the indexed activity max-heap.
package iamh_pkg;

  localparam int unsigned NUM_ELEMENTS = 1024;
  localparam int unsigned EW = 11;            // element / position / count width
  localparam int unsigned SW = 32;            // score width, 16.16
  localparam int unsigned DW = 16;            // decay factor width, 0.16
  localparam int unsigned MW = EW + SW;       // element memory word: {pos, score}

  localparam logic [EW-1:0] N_CNT       = EW'(NUM_ELEMENTS);
  localparam logic [SW-1:0] SCORE_ONE   = 32'h0001_0000;
  localparam logic [DW-1:0] DECAY_RESET = 16'd58982;

  localparam logic [2:0] FN_INSERT = 3'd0;
  localparam logic [2:0] FN_INC    = 3'd1;
  localparam logic [2:0] FN_REMOVE = 3'd2;
  localparam logic [2:0] FN_REDUCE = 3'd3;
  localparam logic [2:0] FN_CLEAR  = 3'd4;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_RM1,
    ST_RM2,
    ST_RM3,
    ST_SD_CHK,
    ST_SD_S,
    ST_SD_E,
    ST_AFT,
    ST_RI,
    ST_SU_CHK,
    ST_SU_S,
    ST_SU_E,
    ST_CLR_R,
    ST_CLR_W,
    ST_DONE
  } state_t;

  function automatic logic [SW-1:0] decayed(input logic [SW-1:0] s, input logic [DW-1:0] f);
    logic [SW+DW-1:0] prod;
    prod = {{DW{1'b0}}, s} * {{SW{1'b0}}, f};
    return prod[SW+DW-1:DW];
  endfunction

endpackage

>>> sv/indexed_activity_max_heap.sv
// Indexed binary max-heap of element numbers with per-element scores.
//
// Usage: drive in_func, in_element and in_increment and raise start while
// busy is low; the word is taken at that clock edge. Exactly one result word
// follows: out_valid is high for one cycle with the top element, the element
// count and the overflow and error flags. The receiver cannot stall, so the
// result is simply presented for that one cycle and busy drops after it.
// The decay factor is written through cfg_valid/cfg_ready/cfg_decay_factor
// and is always ready; write it only while the block is idle.
// Out-of-range elements and unused codes go straight to the result; insert
// and increase climb the heap, remove descends it, and reduce of the top
// element does both of those. A sift walks at most 10 levels, and each
// level reads the slot memory, then reads the element memory, then writes
// both memories. Clearing all scores sweeps the element memory, reading and
// then writing each element.
// After reset the block runs an initialization pass (busy high)
// that loads every slot and element with its reset value.
module indexed_activity_max_heap
  import iamh_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [2:0]    in_func,
  input  logic [EW-1:0] in_element,
  input  logic [SW-1:0] in_increment,
  output logic          out_valid,
  output logic [EW-1:0] out_top_element,
  output logic [EW-1:0] out_heap_count,
  output logic          out_overflow,
  output logic          out_error,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [DW-1:0] cfg_decay_factor
);

  // Slot memory: heap position -> element. Element memory: element -> {pos, score}.
  logic [EW-1:0] slot_mem [0:NUM_ELEMENTS];
  logic [MW-1:0] elem_mem [0:NUM_ELEMENTS];

  logic          s_we;
  logic [EW-1:0] s_wa, s_wd, s_raa, s_rab, s_rda, s_rdb;
  logic          e_we;
  logic [EW-1:0] e_wa, e_raa, e_rab;
  logic [MW-1:0] e_wd, e_rda, e_rdb;

  always_ff @(posedge clk) begin
    if (s_we) slot_mem[s_wa] <= s_wd;
    s_rda <= slot_mem[s_raa];
    s_rdb <= slot_mem[s_rab];
  end

  always_ff @(posedge clk) begin
    if (e_we) elem_mem[e_wa] <= e_wd;
    e_rda <= elem_mem[e_raa];
    e_rdb <= elem_mem[e_rab];
  end

  state_t        state_r, state_nxt;
  logic [EW-1:0] cnt_r, cnt_nxt;
  logic [2:0]    func_r, func_nxt;
  logic [EW-1:0] el_r, el_nxt;
  logic [SW-1:0] inc_r, inc_nxt;
  logic [EW-1:0] m_r, m_nxt;
  logic [SW-1:0] ms_r, ms_nxt;
  logic [EW-1:0] p_r, p_nxt;
  logic [EW-1:0] pe_r, pe_nxt;
  logic [EW-1:0] size_r, size_nxt;
  logic [EW-1:0] top_r;
  logic          ovf_r, ovf_nxt, err_r, err_nxt;
  logic [DW-1:0] decay_r;

  logic          accept, el_ok;
  logic [EW-1:0] a_pos;
  logic [SW-1:0] a_score, b_score;
  logic [SW:0]   sum;
  logic [EW:0]   c_idx;
  logic          take_b;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign el_ok     = (in_element != '0) && (in_element <= N_CNT);
  assign a_pos     = e_rda[MW-1:SW];
  assign a_score   = e_rda[SW-1:0];
  assign b_score   = e_rdb[SW-1:0];
  assign sum       = {1'b0, a_score} + {1'b0, inc_r};
  assign c_idx     = {p_r, 1'b0};
  // Right child wins only when it exists and ranks strictly above the left one.
  assign take_b    = (c_idx < {1'b0, size_r}) && (b_score > a_score);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      cnt_r   <= EW'(1);
      size_r  <= N_CNT;
      top_r   <= EW'(1);
      ovf_r   <= 1'b0;
      err_r   <= 1'b0;
      decay_r <= DECAY_RESET;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      size_r  <= size_nxt;
      ovf_r   <= ovf_nxt;
      err_r   <= err_nxt;
      if (s_we && s_wa == EW'(1)) top_r <= s_wd;
      if (cfg_valid && cfg_ready) decay_r <= cfg_decay_factor;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    el_r   <= el_nxt;
    inc_r  <= inc_nxt;
    m_r    <= m_nxt;
    ms_r   <= ms_nxt;
    p_r    <= p_nxt;
    pe_r   <= pe_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    func_nxt  = func_r;
    el_nxt    = el_r;
    inc_nxt   = inc_r;
    m_nxt     = m_r;
    ms_nxt    = ms_r;
    p_nxt     = p_r;
    pe_nxt    = pe_r;
    size_nxt  = size_r;
    ovf_nxt   = ovf_r;
    err_nxt   = err_r;
    s_we  = 1'b0;
    s_wa  = p_r;
    s_wd  = m_r;
    s_raa = '0;
    s_rab = '0;
    e_we  = 1'b0;
    e_wa  = m_r;
    e_wd  = {p_r, ms_r};
    e_raa = '0;
    e_rab = '0;

    unique case (state_r)
      ST_INIT: begin
        s_we  = 1'b1;
        s_wa  = cnt_r;
        s_wd  = cnt_r;
        e_we  = 1'b1;
        e_wa  = cnt_r;
        e_wd  = {cnt_r, SCORE_ONE};
        cnt_nxt = cnt_r + EW'(1);
        if (cnt_r == N_CNT) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          func_nxt = in_func;
          el_nxt   = in_element;
          inc_nxt  = in_increment;
          ovf_nxt  = 1'b0;
          err_nxt  = 1'b0;
          state_nxt = ST_DONE;
          priority if (in_func == FN_INSERT || in_func == FN_INC
                       || in_func == FN_REDUCE) begin
            if (el_ok) begin
              e_raa     = in_element;
              state_nxt = ST_LOOK;
            end
          end else if (in_func == FN_REMOVE) begin
            if (size_r == '0) begin
              err_nxt = 1'b1;
            end else begin
              e_raa     = top_r;
              s_raa     = size_r;
              state_nxt = ST_RM1;
            end
          end else if (in_func == FN_CLEAR) begin
            cnt_nxt   = EW'(1);
            state_nxt = ST_CLR_R;
          end
        end
      end
      ST_LOOK: begin
        state_nxt = ST_DONE;
        priority if (func_r == FN_INSERT) begin
          if (a_pos == '0 && size_r != N_CNT) begin
            size_nxt  = size_r + EW'(1);
            p_nxt     = size_r + EW'(1);
            m_nxt     = el_r;
            ms_nxt    = a_score;
            state_nxt = ST_SU_CHK;
          end
        end else if (func_r == FN_INC) begin
          if (sum[SW]) begin
            ovf_nxt = 1'b1;
          end else if (a_pos == '0) begin
            e_we = 1'b1;
            e_wa = el_r;
            e_wd = {a_pos, sum[SW-1:0]};
          end else begin
            p_nxt     = a_pos;
            m_nxt     = el_r;
            ms_nxt    = sum[SW-1:0];
            state_nxt = ST_SU_CHK;
          end
        end else begin
          if (a_pos == '0) begin
            e_we = 1'b1;
            e_wa = el_r;
            e_wd = {a_pos, decayed(a_score, decay_r)};
          end else if (top_r != el_r) begin
            err_nxt = 1'b1;
          end else begin
            // The element is the top: take it out, decay it, put it back.
            e_raa     = top_r;
            s_raa     = size_r;
            state_nxt = ST_RM1;
          end
        end
      end
      ST_RM1: begin
        e_we      = 1'b1;
        e_wa      = top_r;
        e_wd      = {{EW{1'b0}}, a_score};
        m_nxt     = s_rda;
        size_nxt  = size_r - EW'(1);
        state_nxt = ST_RM2;
      end
      ST_RM2: begin
        e_raa     = m_r;
        state_nxt = ST_RM3;
      end
      ST_RM3: begin
        ms_nxt    = a_score;
        p_nxt     = EW'(1);
        state_nxt = ST_SD_CHK;
      end
      ST_SD_CHK: begin
        if (c_idx > {1'b0, size_r}) begin
          if (size_r != '0) begin
            s_we = 1'b1;
            e_we = 1'b1;
          end
          state_nxt = ST_AFT;
        end else begin
          s_raa     = c_idx[EW-1:0];
          s_rab     = c_idx[EW-1:0] + EW'(1);
          state_nxt = ST_SD_S;
        end
      end
      ST_SD_S: begin
        e_raa     = s_rda;
        e_rab     = s_rdb;
        pe_nxt    = s_rda;
        cnt_nxt   = s_rdb;
        state_nxt = ST_SD_E;
      end
      ST_SD_E: begin
        if (ms_r > (take_b ? b_score : a_score)) begin
          s_we      = 1'b1;
          e_we      = 1'b1;
          state_nxt = ST_AFT;
        end else begin
          s_we  = 1'b1;
          s_wa  = p_r;
          s_wd  = take_b ? cnt_r : pe_r;
          e_we  = 1'b1;
          e_wa  = take_b ? cnt_r : pe_r;
          e_wd  = {p_r, take_b ? b_score : a_score};
          p_nxt = take_b ? (c_idx[EW-1:0] + EW'(1)) : c_idx[EW-1:0];
          state_nxt = ST_SD_CHK;
        end
      end
      ST_AFT: begin
        if (func_r == FN_REDUCE) begin
          e_raa     = el_r;
          state_nxt = ST_RI;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_RI: begin
        m_nxt     = el_r;
        ms_nxt    = decayed(a_score, decay_r);
        size_nxt  = size_r + EW'(1);
        p_nxt     = size_r + EW'(1);
        state_nxt = ST_SU_CHK;
      end
      ST_SU_CHK: begin
        if (p_r == EW'(1)) begin
          s_we      = 1'b1;
          e_we      = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          s_raa     = p_r >> 1;
          state_nxt = ST_SU_S;
        end
      end
      ST_SU_S: begin
        pe_nxt    = s_rda;
        e_raa     = s_rda;
        state_nxt = ST_SU_E;
      end
      ST_SU_E: begin
        // The parent stays only when it ranks strictly above the rising element.
        if (a_score > ms_r) begin
          s_we      = 1'b1;
          e_we      = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          s_we  = 1'b1;
          s_wd  = pe_r;
          e_we  = 1'b1;
          e_wa  = pe_r;
          e_wd  = {p_r, a_score};
          p_nxt = p_r >> 1;
          state_nxt = ST_SU_CHK;
        end
      end
      ST_CLR_R: begin
        e_raa     = cnt_r;
        state_nxt = ST_CLR_W;
      end
      ST_CLR_W: begin
        e_we    = 1'b1;
        e_wa    = cnt_r;
        e_wd    = {a_pos, {SW{1'b0}}};
        cnt_nxt = cnt_r + EW'(1);
        state_nxt = (cnt_r == N_CNT) ? ST_DONE : ST_CLR_R;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid       = (state_r == ST_DONE);
  assign out_top_element = (size_r != '0) ? top_r : '0;
  assign out_heap_count  = size_r;
  assign out_overflow    = ovf_r;
  assign out_error       = err_r;

  assert property (@(posedge clk) disable iff (!rst_n) size_r <= N_CNT)
    else $error("heap count above capacity");
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid && out_overflow |-> func_r == FN_INC && !out_error)
    else $error("overflow reported outside an increase");
  assert property (@(posedge clk) disable iff (!rst_n)
                   state_r == ST_SD_CHK |-> size_r != N_CNT)
    else $error("sift-down with a full heap");

endmodule

>>> bench/tb_indexed_activity_max_heap.sv
// Self-checking testbench of the indexed activity max-heap with a score-ordered heap predictor.
module tb_indexed_activity_max_heap;
  import iamh_pkg::*;

  localparam logic [2:0] FN_SPARE_5 = 3'd5;
  localparam logic [2:0] FN_SPARE_6 = 3'd6;
  localparam logic [2:0] FN_SPARE_7 = 3'd7;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [EW-1:0] top;
    logic [EW-1:0] count;
    logic          ovf;
    logic          err;
  } heap_word_t;

  class heap_predictor;
    logic [EW-1:0] slot_elem [NUM_ELEMENTS+1];
    logic [EW-1:0] elem_pos  [NUM_ELEMENTS+1];
    logic [SW-1:0] elem_score[NUM_ELEMENTS+1];
    int unsigned   size;
    logic [DW-1:0] decay;
    heap_word_t    expected_words[$];
    int            mismatches;
    int            words_checked;

    function new();
      for (int i = 0; i <= NUM_ELEMENTS; i++) begin
        slot_elem[i] = EW'(i);
        elem_pos[i] = EW'(i);
        elem_score[i] = (i == 0) ? '0 : SCORE_ONE;
      end
      size = NUM_ELEMENTS;
      decay = DECAY_RESET;
      mismatches = 0;
      words_checked = 0;
    endfunction

    function logic [EW-1:0] top_elem();
      return (size != 0) ? slot_elem[1] : '0;
    endfunction

    function void place(logic [EW-1:0] e, int unsigned p);
      slot_elem[p] = e;
      elem_pos[e] = EW'(p);
    endfunction

    function void climb(int unsigned p);
      logic [EW-1:0] e, par;
      e = slot_elem[p];
      while (p > 1) begin
        par = slot_elem[p/2];
        if (elem_score[par] > elem_score[e]) break;
        place(par, p);
        p = p / 2;
      end
      place(e, p);
    endfunction

    function void add_elem(logic [EW-1:0] e);
      if (elem_pos[e] != 0 || size >= NUM_ELEMENTS) return;
      size++;
      slot_elem[size] = e;
      climb(size);
    endfunction

    function void pop_top();
      int unsigned p, c;
      logic [EW-1:0] e, ce;
      p = 1;
      c = 2;
      elem_pos[slot_elem[1]] = '0;
      e = slot_elem[size];
      size--;
      while (c <= size) begin
        ce = slot_elem[c];
        if (c < size && elem_score[slot_elem[c+1]] > elem_score[ce]) begin
          c++;
          ce = slot_elem[c];
        end
        if (elem_score[e] > elem_score[ce]) break;
        place(ce, p);
        p = c;
        c = p * 2;
      end
      if (size != 0) place(e, p);
    endfunction

    function logic [SW-1:0] shrink(logic [SW-1:0] s);
      logic [SW+DW-1:0] prod;
      prod = (SW+DW)'(s) * (SW+DW)'(decay);
      return prod[SW+DW-1:DW];
    endfunction

    function void note_op(logic [2:0] fn, logic [EW-1:0] elem, logic [SW-1:0] inc);
      heap_word_t w;
      logic [SW:0] sum;
      bit in_range;
      in_range = elem >= 1 && elem <= NUM_ELEMENTS;
      w.ovf = 1'b0;
      w.err = 1'b0;
      case (fn)
        FN_INSERT: if (in_range) add_elem(elem);
        FN_INC: if (in_range) begin
          sum = {1'b0, elem_score[elem]} + {1'b0, inc};
          if (sum[SW]) w.ovf = 1'b1;
          else begin
            elem_score[elem] = sum[SW-1:0];
            if (elem_pos[elem] != 0) climb(elem_pos[elem]);
          end
        end
        FN_REMOVE: if (size == 0) w.err = 1'b1; else pop_top();
        FN_REDUCE: if (in_range) begin
          if (elem_pos[elem] == 0) elem_score[elem] = shrink(elem_score[elem]);
          else if (slot_elem[1] != elem) w.err = 1'b1;
          else begin
            pop_top();
            elem_score[elem] = shrink(elem_score[elem]);
            add_elem(elem);
          end
        end
        FN_CLEAR: for (int i = 1; i <= NUM_ELEMENTS; i++) elem_score[i] = '0;
        default: ;
      endcase
      w.top = top_elem();
      w.count = EW'(size);
      expected_words.push_back(w);
    endfunction

    function void check_word(heap_word_t got);
      heap_word_t exp_w;
      words_checked++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word top=%0d count=%0d", $time, got.top, got.count);
        mismatches++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.top !== exp_w.top) begin
        $display("%0t: top_element expected %0d actual %0d", $time, exp_w.top, got.top);
        mismatches++;
      end
      if (got.count !== exp_w.count) begin
        $display("%0t: heap_count expected %0d actual %0d", $time, exp_w.count, got.count);
        mismatches++;
      end
      if (got.ovf !== exp_w.ovf) begin
        $display("%0t: overflow expected %0b actual %0b", $time, exp_w.ovf, got.ovf);
        mismatches++;
      end
      if (got.err !== exp_w.err) begin
        $display("%0t: error expected %0b actual %0b", $time, exp_w.err, got.err);
        mismatches++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [2:0]    in_func = '0;
  logic [EW-1:0] in_element = '0;
  logic [SW-1:0] in_increment = '0;
  logic          out_valid;
  logic [EW-1:0] out_top_element;
  logic [EW-1:0] out_heap_count;
  logic          out_overflow;
  logic          out_error;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [DW-1:0] cfg_decay_factor = '0;

  heap_predictor model = new();
  int idle_pct = 0;
  int ops_sent = 0;
  int stall_cycles = 0;

  indexed_activity_max_heap u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_element(in_element), .in_increment(in_increment),
    .out_valid(out_valid), .out_top_element(out_top_element),
    .out_heap_count(out_heap_count), .out_overflow(out_overflow), .out_error(out_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_decay_factor(cfg_decay_factor)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      model.check_word('{out_top_element, out_heap_count, out_overflow, out_error});
  end

  // The watchdog restarts whenever a word moves in either direction.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_op(logic [2:0] fn, logic [EW-1:0] elem, logic [SW-1:0] inc);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= fn;
    in_element <= elem;
    in_increment <= inc;
    do @(posedge clk); while (busy);
    model.note_op(fn, elem, inc);
    ops_sent++;
  endtask

  task automatic write_decay(logic [DW-1:0] val);
    start <= 1'b0;
    while (model.expected_words.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_decay_factor <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model.decay = val;
    @(posedge clk);
  endtask

  task automatic random_op();
    int pick;
    logic [EW-1:0] elem;
    logic [SW-1:0] inc;
    pick = $urandom_range(99);
    elem = EW'($urandom_range(1, NUM_ELEMENTS));
    if ($urandom_range(19) == 0) elem = EW'($urandom);
    inc = ($urandom_range(3) == 0) ? $urandom : SW'($urandom_range(0, 32'h0004_0000));
    if (pick < 30) send_op(FN_INC, elem, inc);
    else if (pick < 50) send_op(FN_INSERT, elem, inc);
    else if (pick < 68) send_op(FN_REMOVE, EW'($urandom), inc);
    else if (pick < 82) send_op(FN_REDUCE, model.top_elem(), inc);
    else if (pick < 95) send_op(FN_REDUCE, elem, inc);
    else if (pick < 96) send_op(FN_CLEAR, EW'($urandom), inc);
    else send_op(3'($urandom_range(5, 7)), elem, inc);
  endtask

  initial begin
    int waited;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners against the reset heap.
    send_op(FN_INSERT, 11'd5, '0);
    send_op(FN_INC, 11'd1, 32'hFFFF_FFFF);
    send_op(FN_INC, 11'd700, 32'h0001_0000);
    send_op(FN_INC, 11'd1024, 32'hFFFE_FFFF);
    send_op(FN_REDUCE, 11'd2, '0);
    send_op(FN_REDUCE, model.top_elem(), '0);
    send_op(FN_REMOVE, 11'd0, '0);
    send_op(FN_INC, 11'd1024, 32'h0000_0123);
    send_op(FN_REDUCE, 11'd1024, '0);
    send_op(FN_INSERT, 11'd1024, '0);
    send_op(FN_INSERT, 11'd0, '0);
    send_op(FN_INC, 11'd1025, 32'h0001_0000);
    send_op(FN_REDUCE, 11'd2047, '0);
    send_op(FN_SPARE_5, 11'd3, '0);
    send_op(FN_SPARE_6, 11'd3, '0);
    send_op(FN_SPARE_7, 11'd3, '0);
    send_op(FN_INC, 11'd9, '0);
    send_op(FN_CLEAR, 11'd0, '0);
    send_op(FN_INC, 11'd17, 32'h0000_0001);
    send_op(FN_REDUCE, model.top_elem(), '0);

    write_decay(16'hFFFF);
    idle_pct = 0;
    repeat (220) random_op();

    write_decay(16'h0000);
    idle_pct = 81;
    repeat (220) random_op();

    // Drain the heap completely, then push on the empty heap.
    write_decay(16'($urandom));
    idle_pct = 0;
    while (model.size != 0) send_op(FN_REMOVE, EW'($urandom), $urandom);
    send_op(FN_REMOVE, '0, '0);
    send_op(FN_REDUCE, 11'd1, '0);
    repeat (220) random_op();

    write_decay(DECAY_RESET);
    idle_pct = 19;
    repeat (220) random_op();
    start <= 1'b0;

    waited = 0;
    while (model.expected_words.size() != 0 && waited < STALL_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (model.expected_words.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, model.expected_words.size());
      model.mismatches++;
    end
    $display("Ran %0d heap operations over four decay settings, including a full drain.",
             ops_sent);
    $display("Checked %0d result words, %0d mismatches.", model.words_checked, model.mismatches);
    if (model.mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
